[hw/rtl/mbrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared codes, command/status bundles and CRC helper for the RTU slave.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_READ_HOLD   = 8'h03;
  localparam logic [7:0] FN_READ_INPUT  = 8'h04;
  localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FN_WRITE_REG   = 8'h06;
  localparam logic [7:0] FN_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FN_WRITE_REGS  = 8'h10;
  localparam logic [7:0] FN_REBOOT      = 8'h23;
  localparam logic [7:0] FN_ECHO        = 8'h25;

  localparam logic [7:0]  EXC_FLAG       = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FN = 8'h01;
  localparam logic [15:0] COIL_ADDR_MASK = 16'h03FF;
  localparam logic [15:0] REG_ADDR_MASK  = 16'h0FFF;
  localparam logic [10:0] MAX_COILS      = 11'd2000;
  localparam logic [10:0] MAX_REGS       = 11'd125;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam int unsigned TX_DEPTH       = 256;
  localparam int unsigned MIN_FRAME      = 5;

  typedef enum logic [3:0] {
    TX_CONST, TX_ID, TX_FN, TX_FN_EXC, TX_W2H, TX_W2L, TX_W4H, TX_W4L,
    TX_ACC, TX_REG_HI, TX_REG_LO, TX_CRC_LO, TX_CRC_HI, TX_BC, TX_N2
  } tx_src_e;

  typedef enum logic [1:0] {
    RX_HDR, RX_COIL_BYTE, RX_REG_HI, RX_REG_LO
  } rx_src_e;

  typedef struct packed {
    logic       rx_wr;
    logic       rx_clr;
    logic       rx_rd;
    rx_src_e    rx_src;
    logic       hdr_cap;
    logic       idx_clr;
    logic       idx_inc;
    logic       ld_addr;
    logic       addr_sub;
    logic       addr_inc;
    logic       acc_clr;
    logic       acc_ld;
    logic       coil_rd;
    logic       coil_shift;
    logic       coil_wr;
    logic       coil_multi;
    logic       reg_rd;
    logic       reg_wr;
    logic       reg_multi;
    logic       tx_init;
    logic       tx_wr;
    logic       tx_crc_en;
    tx_src_e    tx_src;
    logic [7:0] tx_const;
    logic       tx_commit;
    logic       tx_rd;
    logic       emit_pull;
    logic       emit_reboot;
    logic       clr_wr;
  } cmd_t;

  typedef struct packed {
    logic [7:0] fn;
    logic       tx_pend;
    logic       frame_ok;
    logic       idx_end;
    logic       idx_lo0;
    logic       idx_lo7;
    logic       addr_ge;
    logic       hdr_done;
    logic       clr_done;
    logic       out_free;
  } sts_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // "XTAPP" tag of the echo test reply, by reply step
  function automatic logic [7:0] echo_tag(logic [2:0] k);
    logic [7:0] r;
    unique case (k)
      3'd2:       r = 8'h58;
      3'd3:       r = 8'h54;
      3'd4:       r = 8'h41;
      3'd5, 3'd6: r = 8'h50;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/mbrtu_in_if.sv]
// ----------------------------------------------------------------------------
// mbrtu_in_if
// Input item channel: received byte or reply-pull request.
// ----------------------------------------------------------------------------
interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output op, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input op, input rx_byte, input frame_end, output ready);
endinterface

[hw/rtl/mbrtu_out_if.sv]
// ----------------------------------------------------------------------------
// mbrtu_out_if
// Result item channel: reply byte or reboot request.
// ----------------------------------------------------------------------------
interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       reboot_request;

  modport source (output valid, output tx_byte, output tx_last, output reboot_request,
                  input ready);
  modport sink   (input valid, input tx_byte, input tx_last, input reboot_request,
                  output ready);
endinterface

[hw/rtl/mbrtu_dpath.sv]
// ----------------------------------------------------------------------------
// mbrtu_dpath
// Frame/reply buffers, coil and register stores, counters and output register.
// ----------------------------------------------------------------------------
module mbrtu_dpath import mbrtu_pkg::*; #(
  parameter int unsigned FRAME_BYTES    = 256,
  parameter int unsigned REGISTER_WORDS = 4096,
  parameter int unsigned COIL_BITS      = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic [7:0] rx_byte_i,
  input  cmd_t       cmd_i,
  input  logic       out_ready_i,
  output sts_t       sts_o,
  output logic       out_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_last_o,
  output logic       reboot_request_o
);

  localparam int unsigned FIW   = $clog2(FRAME_BYTES);
  localparam int unsigned RCW   = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CBW   = $clog2(COIL_BITS);
  localparam int unsigned RWW   = $clog2(REGISTER_WORDS);
  localparam int unsigned CLR_N = (COIL_BITS > REGISTER_WORDS) ? COIL_BITS : REGISTER_WORDS;
  localparam int unsigned CLW   = $clog2(CLR_N + 1);
  localparam int unsigned TXW   = $clog2(TX_DEPTH);

  logic             offset_q;
  logic [RCW-1:0]   rx_cnt_q;
  logic [15:0]      rx_crc_q;
  logic [7:0]       rx_mem [FRAME_BYTES];
  logic [7:0]       rx_rdata_q;
  logic             rx_ok_q;
  logic [7:0]       rx_data;
  logic             rx_room;
  logic [12:0]      rx_idx;
  logic             rx_in;
  logic [7:0]       hdr_q [6];
  logic [2:0]       hdr_slot;
  logic [7:0]       fn;
  logic [15:0]      word2, word4;
  logic             is_coil;
  logic [10:0]      idx_q, cnt_q, lim, cnt_ld;
  logic [7:0]       acc_q;
  logic [15:0]      addr_q, addr_sum, addr_start;
  logic [16:0]      size17, addr_ext, addr_nx;
  logic             coil_mem [COIL_BITS];
  logic             coil_rdata_q, coil_val;
  logic [15:0]      reg_mem [REGISTER_WORDS];
  logic [15:0]      reg_rdata_q, reg_val;
  logic [CLW-1:0]   clr_q;
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [TXW-1:0]   wptr_q;
  logic [15:0]      tx_crc_q;
  logic [8:0]       tx_len_q, tx_pos_q, pos_nx;
  logic [7:0]       tx_rdata_q, tx_data;
  logic             out_valid_q, tx_last_q, reboot_q;
  logic [7:0]       tx_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 1'b1;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // receive side
  assign rx_room = rx_cnt_q < RCW'(FRAME_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cnt_q <= '0;
      rx_crc_q <= CRC_INIT;
    end else if (cmd_i.rx_clr) begin
      rx_cnt_q <= '0;
      rx_crc_q <= CRC_INIT;
    end else if (cmd_i.rx_wr && rx_room) begin
      rx_cnt_q <= rx_cnt_q + RCW'(1);
      rx_crc_q <= crc16_byte(rx_crc_q, rx_byte_i);
    end
  end

  always_comb begin
    unique case (cmd_i.rx_src)
      RX_HDR:       rx_idx = 13'(idx_q);
      RX_COIL_BYTE: rx_idx = 13'd7 + 13'(idx_q[10:3]);
      RX_REG_HI:    rx_idx = 13'd7 + {1'b0, idx_q, 1'b0};
      RX_REG_LO:    rx_idx = 13'd8 + {1'b0, idx_q, 1'b0};
      default:      rx_idx = '0;
    endcase
  end
  assign rx_in = rx_idx < 13'(rx_cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_wr && rx_room) begin
      rx_mem[rx_cnt_q[FIW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rx_rd) begin
      rx_ok_q <= rx_in;
      if (rx_in) begin
        rx_rdata_q <= rx_mem[rx_idx[FIW-1:0]];
      end
    end
  end
  // bytes past the received length read as zero
  assign rx_data = rx_ok_q ? rx_rdata_q : 8'h00;

  // request header
  assign hdr_slot = idx_q[2:0] - 3'd1;
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_cap) begin
      hdr_q[hdr_slot] <= rx_data;
    end
  end
  assign fn      = hdr_q[1];
  assign word2   = {hdr_q[2], hdr_q[3]};
  assign word4   = {hdr_q[4], hdr_q[5]};
  assign is_coil = (fn == FN_READ_COILS) || (fn == FN_WRITE_COIL) || (fn == FN_WRITE_COILS);

  // address and count
  assign size17     = is_coil ? 17'(COIL_BITS) : 17'(REGISTER_WORDS);
  assign addr_sum   = word2 + {15'd0, offset_q};
  assign addr_start = addr_sum & (is_coil ? COIL_ADDR_MASK : REG_ADDR_MASK);
  assign addr_ext   = {1'b0, addr_q};
  assign addr_nx    = addr_ext + 17'd1;
  assign lim        = is_coil ? MAX_COILS : MAX_REGS;
  assign cnt_ld     = (word4 > {5'd0, lim}) ? lim : word4[10:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_addr) begin
      addr_q <= addr_start;
      cnt_q  <= cnt_ld;
    end else if (cmd_i.addr_sub) begin
      addr_q <= 16'(addr_ext - size17);
    end else if (cmd_i.addr_inc) begin
      addr_q <= (addr_nx == size17) ? 16'd0 : addr_nx[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 11'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_ld) begin
      acc_q <= rx_data;
    end else if (cmd_i.coil_shift) begin
      acc_q <= acc_q | (8'(coil_rdata_q) << idx_q[2:0]);
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + CLW'(1);
    end
  end

  // coil and register stores
  assign coil_val = cmd_i.coil_multi ? acc_q[idx_q[2:0]] : (word4 != 16'd0);
  assign reg_val  = cmd_i.reg_multi ? {acc_q, rx_data} : word4;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      if (clr_q < CLW'(COIL_BITS)) begin
        coil_mem[clr_q[CBW-1:0]] <= 1'b0;
      end
    end else if (cmd_i.coil_wr) begin
      coil_mem[addr_q[CBW-1:0]] <= coil_val;
    end
    if (cmd_i.coil_rd) begin
      coil_rdata_q <= coil_mem[addr_q[CBW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      if (clr_q < CLW'(REGISTER_WORDS)) begin
        reg_mem[clr_q[RWW-1:0]] <= 16'd0;
      end
    end else if (cmd_i.reg_wr) begin
      reg_mem[addr_q[RWW-1:0]] <= reg_val;
    end
    if (cmd_i.reg_rd) begin
      reg_rdata_q <= reg_mem[addr_q[RWW-1:0]];
    end
  end

  // reply buffer
  always_comb begin
    unique case (cmd_i.tx_src)
      TX_CONST:  tx_data = cmd_i.tx_const;
      TX_ID:     tx_data = hdr_q[0];
      TX_FN:     tx_data = fn;
      TX_FN_EXC: tx_data = fn | EXC_FLAG;
      TX_W2H:    tx_data = hdr_q[2];
      TX_W2L:    tx_data = hdr_q[3];
      TX_W4H:    tx_data = hdr_q[4];
      TX_W4L:    tx_data = hdr_q[5];
      TX_ACC:    tx_data = acc_q;
      TX_REG_HI: tx_data = reg_rdata_q[15:8];
      TX_REG_LO: tx_data = reg_rdata_q[7:0];
      TX_CRC_LO: tx_data = tx_crc_q[7:0];
      TX_CRC_HI: tx_data = tx_crc_q[15:8];
      TX_BC:     tx_data = 8'((cnt_q + 11'd7) >> 3);
      TX_N2:     tx_data = 8'({cnt_q, 1'b0});
      default:   tx_data = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tx_init) begin
      wptr_q   <= '0;
      tx_crc_q <= CRC_INIT;
    end else if (cmd_i.tx_wr) begin
      wptr_q <= wptr_q + TXW'(1);
      if (cmd_i.tx_crc_en) begin
        tx_crc_q <= crc16_byte(tx_crc_q, tx_data);
      end
    end
    if (cmd_i.tx_wr) begin
      tx_mem[wptr_q] <= tx_data;
    end
    if (cmd_i.tx_rd) begin
      tx_rdata_q <= tx_mem[tx_pos_q[TXW-1:0]];
    end
  end

  assign pos_nx = tx_pos_q + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_len_q <= '0;
      tx_pos_q <= '0;
    end else if (cmd_i.tx_commit) begin
      tx_len_q <= {1'b0, wptr_q};
      tx_pos_q <= '0;
    end else if (cmd_i.emit_pull) begin
      if (pos_nx >= tx_len_q) begin
        tx_len_q <= '0;
        tx_pos_q <= '0;
      end else begin
        tx_pos_q <= pos_nx;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pull || cmd_i.emit_reboot) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pull) begin
      tx_byte_q <= tx_rdata_q;
      tx_last_q <= pos_nx >= tx_len_q;
      reboot_q  <= 1'b0;
    end else if (cmd_i.emit_reboot) begin
      tx_byte_q <= 8'h00;
      tx_last_q <= 1'b0;
      reboot_q  <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_byte_o        = tx_byte_q;
  assign tx_last_o        = tx_last_q;
  assign reboot_request_o = reboot_q;

  always_comb begin
    sts_o.fn       = fn;
    sts_o.tx_pend  = tx_len_q != 9'd0;
    sts_o.frame_ok = (rx_cnt_q >= RCW'(MIN_FRAME)) && (rx_crc_q == 16'd0);
    sts_o.idx_end  = idx_q == cnt_q;
    sts_o.idx_lo0  = idx_q[2:0] == 3'd0;
    sts_o.idx_lo7  = idx_q[2:0] == 3'd7;
    sts_o.addr_ge  = addr_ext >= size17;
    sts_o.hdr_done = idx_q == 11'd6;
    sts_o.clr_done = clr_q == CLW'(CLR_N);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

[hw/rtl/mbrtu_ctrl.sv]
// ----------------------------------------------------------------------------
// mbrtu_ctrl
// Sequencer: item intake, frame service per function code, reply pulls.
// ----------------------------------------------------------------------------
module mbrtu_ctrl import mbrtu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  input  logic in_frame_end_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHECK, S_HDR, S_DISP, S_FN, S_AMOD,
    S_RC_LOOP, S_RC_WT, S_RC_WR, S_RR_LOOP, S_RR_WT, S_RR_LO,
    S_WC_LOOP, S_WC_LD, S_WC_WR, S_WR_LOOP, S_WR_H, S_WR_L,
    S_ECHO, S_TEST, S_EXC, S_CRC_LO, S_CRC_HI, S_FIN, S_RBT, S_PULL, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       in_acc;

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.clr_wr = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_op_i) begin
            if (sts_i.tx_pend) begin
              cmd_o.tx_rd = 1'b1;
              state_d     = S_PULL;
            end
          end else if (!sts_i.tx_pend) begin
            cmd_o.rx_wr = 1'b1;
            if (in_frame_end_i) begin
              state_d = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        if (sts_i.frame_ok) begin
          cmd_o.tx_init = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_HDR;
        end else begin
          cmd_o.rx_clr = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_HDR: begin
        // read bytes 0..5, capture each in the cycle after its read
        cmd_o.rx_src  = RX_HDR;
        cmd_o.rx_rd   = !sts_i.hdr_done;
        cmd_o.hdr_cap = !sts_i.idx_lo0;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.hdr_done) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.ld_addr   = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        cmd_o.acc_clr   = 1'b1;
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        cmd_o.tx_src    = TX_ID;
        state_d = (sts_i.fn == FN_REBOOT) ? S_RBT : S_FN;
      end
      S_FN: begin
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        cmd_o.tx_src    = TX_FN;
        unique case (sts_i.fn)
          FN_READ_COILS, FN_READ_HOLD, FN_READ_INPUT, FN_WRITE_COIL,
          FN_WRITE_REG, FN_WRITE_COILS, FN_WRITE_REGS: state_d = S_AMOD;
          FN_ECHO:                                     state_d = S_TEST;
          default: begin
            cmd_o.tx_src = TX_FN_EXC;
            state_d      = S_EXC;
          end
        endcase
      end
      S_AMOD: begin
        // reduce the start address into the store, then branch
        if (sts_i.addr_ge) begin
          cmd_o.addr_sub = 1'b1;
        end else begin
          unique case (sts_i.fn)
            FN_READ_COILS: begin
              cmd_o.tx_wr     = 1'b1;
              cmd_o.tx_crc_en = 1'b1;
              cmd_o.tx_src    = TX_BC;
              state_d         = S_RC_LOOP;
            end
            FN_READ_HOLD, FN_READ_INPUT: begin
              cmd_o.tx_wr     = 1'b1;
              cmd_o.tx_crc_en = 1'b1;
              cmd_o.tx_src    = TX_N2;
              state_d         = S_RR_LOOP;
            end
            FN_WRITE_COIL: begin
              cmd_o.coil_wr = 1'b1;
              state_d       = S_ECHO;
            end
            FN_WRITE_REG: begin
              cmd_o.reg_wr = 1'b1;
              state_d      = S_ECHO;
            end
            FN_WRITE_COILS: state_d = S_WC_LOOP;
            default:        state_d = S_WR_LOOP;
          endcase
        end
      end
      S_RC_LOOP: begin
        if (sts_i.idx_end) begin
          if (!sts_i.idx_lo0) begin
            cmd_o.tx_wr     = 1'b1;
            cmd_o.tx_crc_en = 1'b1;
            cmd_o.tx_src    = TX_ACC;
          end
          state_d = S_CRC_LO;
        end else begin
          cmd_o.coil_rd = 1'b1;
          state_d       = S_RC_WT;
        end
      end
      S_RC_WT: begin
        cmd_o.coil_shift = 1'b1;
        cmd_o.idx_inc    = 1'b1;
        cmd_o.addr_inc   = 1'b1;
        state_d = sts_i.idx_lo7 ? S_RC_WR : S_RC_LOOP;
      end
      S_RC_WR: begin
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        cmd_o.tx_src    = TX_ACC;
        cmd_o.acc_clr   = 1'b1;
        state_d         = S_RC_LOOP;
      end
      S_RR_LOOP: begin
        if (sts_i.idx_end) begin
          state_d = S_CRC_LO;
        end else begin
          cmd_o.reg_rd = 1'b1;
          state_d      = S_RR_WT;
        end
      end
      S_RR_WT: begin
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        cmd_o.tx_src    = TX_REG_HI;
        state_d         = S_RR_LO;
      end
      S_RR_LO: begin
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        cmd_o.tx_src    = TX_REG_LO;
        cmd_o.idx_inc   = 1'b1;
        cmd_o.addr_inc  = 1'b1;
        state_d         = S_RR_LOOP;
      end
      S_WC_LOOP: begin
        if (sts_i.idx_end) begin
          state_d = S_ECHO;
        end else if (sts_i.idx_lo0) begin
          cmd_o.rx_rd  = 1'b1;
          cmd_o.rx_src = RX_COIL_BYTE;
          state_d      = S_WC_LD;
        end else begin
          state_d = S_WC_WR;
        end
      end
      S_WC_LD: begin
        cmd_o.acc_ld = 1'b1;
        state_d      = S_WC_WR;
      end
      S_WC_WR: begin
        cmd_o.coil_wr    = 1'b1;
        cmd_o.coil_multi = 1'b1;
        cmd_o.idx_inc    = 1'b1;
        cmd_o.addr_inc   = 1'b1;
        state_d          = S_WC_LOOP;
      end
      S_WR_LOOP: begin
        if (sts_i.idx_end) begin
          state_d = S_ECHO;
        end else begin
          cmd_o.rx_rd  = 1'b1;
          cmd_o.rx_src = RX_REG_HI;
          state_d      = S_WR_H;
        end
      end
      S_WR_H: begin
        cmd_o.acc_ld = 1'b1;
        cmd_o.rx_rd  = 1'b1;
        cmd_o.rx_src = RX_REG_LO;
        state_d      = S_WR_L;
      end
      S_WR_L: begin
        cmd_o.reg_wr    = 1'b1;
        cmd_o.reg_multi = 1'b1;
        cmd_o.idx_inc   = 1'b1;
        cmd_o.addr_inc  = 1'b1;
        state_d         = S_WR_LOOP;
      end
      S_ECHO: begin
        // write replies echo request bytes 2..5
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        step_d          = step_q + 3'd1;
        unique case (step_q)
          3'd0:    cmd_o.tx_src = TX_W2H;
          3'd1:    cmd_o.tx_src = TX_W2L;
          3'd2:    cmd_o.tx_src = TX_W4H;
          default: cmd_o.tx_src = TX_W4L;
        endcase
        if (step_q == 3'd3) begin
          state_d = S_CRC_LO;
        end
      end
      S_TEST: begin
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        step_d          = step_q + 3'd1;
        unique case (step_q)
          3'd0:    cmd_o.tx_src = TX_W2H;
          3'd1:    cmd_o.tx_src = TX_W2L;
          default: begin
            cmd_o.tx_src   = TX_CONST;
            cmd_o.tx_const = echo_tag(step_q);
          end
        endcase
        if (step_q == 3'd6) begin
          state_d = S_CRC_LO;
        end
      end
      S_EXC: begin
        cmd_o.tx_wr     = 1'b1;
        cmd_o.tx_crc_en = 1'b1;
        cmd_o.tx_src    = TX_CONST;
        cmd_o.tx_const  = EXC_ILLEGAL_FN;
        state_d         = S_CRC_LO;
      end
      S_CRC_LO: begin
        cmd_o.tx_wr  = 1'b1;
        cmd_o.tx_src = TX_CRC_LO;
        state_d      = S_CRC_HI;
      end
      S_CRC_HI: begin
        cmd_o.tx_wr  = 1'b1;
        cmd_o.tx_src = TX_CRC_HI;
        state_d      = S_FIN;
      end
      S_FIN: begin
        cmd_o.tx_commit = 1'b1;
        cmd_o.rx_clr    = 1'b1;
        state_d         = S_IDLE;
      end
      S_RBT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_reboot = 1'b1;
          cmd_o.rx_clr      = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_PULL: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pull = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/modbus_rtu_slave_engine.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine
// RTU slave: buffers one frame, checks CRC, serves coils/registers, and hands
//   out the reply one byte per pull item.
// Service: a non-final byte is buffered; a reply pull reads the reply buffer,
//   then loads the output register once it is free. A good final byte starts
//   frame service (header fetch, dispatch, reply header or echo, CRC append)
//   with a loop step per coil or register read or written. A dropped frame is
//   cleared; a reboot frame waits for the output register to be free.
// Throughput: one item at a time; the sequencer and the single-port stores set
//   the pace.
// Reset: stores are swept to zero, during which no item is taken; config writes
//   still land.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_engine import mbrtu_pkg::*; #(
  parameter int unsigned FRAME_BYTES    = 256,
  parameter int unsigned REGISTER_WORDS = 4096,
  parameter int unsigned COIL_BITS      = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,     // address_offset write
  input  logic        cfg_wdata_i,
  mbrtu_in_if.sink    rx_item_i,
  mbrtu_out_if.source tx_item_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller: walks each good frame through header fetch, address reduction,
  // the per-code loop and CRC append, as its function code needs.
  mbrtu_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (rx_item_i.valid),
    .in_op_i        (rx_item_i.op),
    .in_frame_end_i (rx_item_i.frame_end),
    .in_ready_o     (rx_item_i.ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // Datapath: frame and reply buffers, stores, and the result register that
  // decouples the output handshake from the sequencer.
  mbrtu_dpath #(
    .FRAME_BYTES    (FRAME_BYTES),
    .REGISTER_WORDS (REGISTER_WORDS),
    .COIL_BITS      (COIL_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_byte_i        (rx_item_i.rx_byte),
    .cmd_i            (cmd),
    .out_ready_i      (tx_item_o.ready),
    .sts_o            (sts),
    .out_valid_o      (tx_item_o.valid),
    .tx_byte_o        (tx_item_o.tx_byte),
    .tx_last_o        (tx_item_o.tx_last),
    .reboot_request_o (tx_item_o.reboot_request)
  );

endmodule

[hw/rtl/mbrtu_chk.sv]
// ----------------------------------------------------------------------------
// mbrtu_chk
// Port-level checks on the result channel of the RTU slave.
// ----------------------------------------------------------------------------
module mbrtu_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       tx_last_i,
  input logic       reboot_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tx_byte_i) && $stable(tx_last_i)
                                    && $stable(reboot_i))
    else $error("result item changed while stalled");

  a_reboot_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reboot_i |-> !tx_last_i)
    else $error("reboot item flagged as last reply byte");

  a_reboot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reboot_i |-> tx_byte_i == 8'h00)
    else $error("reboot item carries a reply byte");

endmodule

bind modbus_rtu_slave_engine mbrtu_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (tx_item_o.valid),
  .out_ready_i (tx_item_o.ready),
  .tx_byte_i   (tx_item_o.tx_byte),
  .tx_last_i   (tx_item_o.tx_last),
  .reboot_i    (tx_item_o.reboot_request)
);
